// ===== sv/euler_to_inverse_rotation_matrix_unit_macros.svh =====
// Assertion macros for the checker file of the rotation matrix unit.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef EULER_TO_INVERSE_ROTATION_MATRIX_UNIT_MACROS_SVH
`define EULER_TO_INVERSE_ROTATION_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define E2IRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e2irm assertion failed");

// Next-cycle implication, quiet during reset.
`define E2IRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("e2irm assertion failed");

`endif

// ===== sv/e2irm_pkg.sv =====
// Shared types, constants and the arctangent table of the rotation matrix unit.
// Depends on nothing.
package e2irm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int CORDIC_STEPS   = 28;
  localparam int OUT_BITS       = 16;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  // Q30 CORDIC gain compensation start value
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  // one angle's working set as it travels down the cell chain
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               flip;
  } lane_t;

  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  function automatic logic signed [31:0] atan_step(input logic [STEP_W-1:0] s);
    logic signed [31:0] r;
    r = 32'sd0;
    if (int'(s) < CORDIC_STEPS) r = $signed(ATAN_TURN32[s]);
    return r;
  endfunction

endpackage

// ===== sv/euler_to_inverse_rotation_matrix_unit.sv =====
// Top level: angle intake, CORDIC cell chain and product pipeline.
// Depends on e2irm_pkg, e2irm_cordic_cell and e2irm_product.

// Takes one roll/pitch/yaw beat per clock unless in_stall is high and returns the
// nine elements of the transposed ZYX rotation matrix in signed Q2.14, clamped
// to +-1.0. The pipeline is one intake register, 28 CORDIC cells (one per
// iteration, all three angles side by side), then fix-up, two multiplier
// stages and the output register. The whole pipeline advances together and
// holds while a result waits under out_stall; in_stall is high only then.
module euler_to_inverse_rotation_matrix_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_yaw_angle,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_00,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_01,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_02,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_10,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_11,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_12,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_20,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_21,
  output logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_22
);

  localparam int N = e2irm_pkg::CORDIC_STEPS;

  logic en;
  logic in_valid_r;
  e2irm_pkg::lane_t lane0_r  [3];
  e2irm_pkg::lane_t lane0_nxt[3];
  logic [e2irm_pkg::ANGLE_BITS-1:0] ang [3];

  logic             chain_valid [N+1];
  e2irm_pkg::lane_t chain_lane  [N+1][3];

  logic [e2irm_pkg::OUT_BITS-1:0] m [9];

  // pipeline moves unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign ang[0] = in_roll_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_yaw_angle;

  // angle to 32-bit phase; second and third quadrants turned by pi
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] ph;
      ph = 32'(ang[k]) << (32 - e2irm_pkg::ANGLE_BITS);
      lane0_nxt[k].flip = ph[31] ^ ph[30];
      if (lane0_nxt[k].flip) ph[31] = ~ph[31];
      lane0_nxt[k].z = $signed(ph);
      lane0_nxt[k].x = e2irm_pkg::CORDIC_X0;
      lane0_nxt[k].y = 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane0_r <= lane0_nxt;
    end
  end

  assign chain_valid[0] = in_valid_r;
  assign chain_lane[0]  = lane0_r;

  // CORDIC cell chain, one iteration per cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    e2irm_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .step       (e2irm_pkg::STEP_W'(i)),
      .prev_valid (chain_valid[i]),
      .prev_lane  (chain_lane[i]),
      .cell_valid (chain_valid[i+1]),
      .cell_lane  (chain_lane[i+1])
    );
  end

  e2irm_product u_product (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .prev_valid (chain_valid[N]),
    .prev_lane  (chain_lane[N]),
    .out_valid  (out_valid),
    .out_m      (m)
  );

  assign out_m_00 = m[0];
  assign out_m_01 = m[1];
  assign out_m_02 = m[2];
  assign out_m_10 = m[3];
  assign out_m_11 = m[4];
  assign out_m_12 = m[5];
  assign out_m_20 = m[6];
  assign out_m_21 = m[7];
  assign out_m_22 = m[8];

endmodule

// ===== sv/e2irm_cordic_cell.sv =====
// One CORDIC rotation step applied to the roll, pitch and yaw lanes.
// Depends on e2irm_pkg.
module e2irm_cordic_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [e2irm_pkg::STEP_W-1:0]   step,
  input  logic                           prev_valid,
  input  e2irm_pkg::lane_t               prev_lane [3],
  output logic                           cell_valid,
  output e2irm_pkg::lane_t               cell_lane [3]
);

  logic             valid_r;
  e2irm_pkg::lane_t lane_r   [3];
  e2irm_pkg::lane_t lane_nxt [3];
  logic signed [31:0] atan_c;

  assign atan_c = e2irm_pkg::atan_step(step);

  // micro-rotation toward z = 0, floor shifts
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_nxt[k].flip = prev_lane[k].flip;
      if (!prev_lane[k].z[31]) begin
        lane_nxt[k].x = prev_lane[k].x - (prev_lane[k].y >>> step);
        lane_nxt[k].y = prev_lane[k].y + (prev_lane[k].x >>> step);
        lane_nxt[k].z = prev_lane[k].z - atan_c;
      end else begin
        lane_nxt[k].x = prev_lane[k].x + (prev_lane[k].y >>> step);
        lane_nxt[k].y = prev_lane[k].y - (prev_lane[k].x >>> step);
        lane_nxt[k].z = prev_lane[k].z + atan_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_lane  = lane_r;

endmodule

// ===== sv/e2irm_product.sv =====
// Quadrant fix-up, products, rounding and saturation into the output register.
// Depends on e2irm_pkg.
module e2irm_product (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                prev_valid,
  input  e2irm_pkg::lane_t                    prev_lane [3],
  output logic                                out_valid,
  output logic [e2irm_pkg::OUT_BITS-1:0]      out_m [9]
);

  localparam int SH = 60 - e2irm_pkg::COEF_FRAC_BITS;

  // stage A: sine and cosine after quadrant fix-up
  logic va_r;
  logic signed [31:0] sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  // stage B: first products
  logic vb_r;
  logic signed [63:0] cycp_r, sycp_r, cysp_r, sysp_r, cpsr_r, cpcr_r;
  logic signed [63:0] sycr_r, cycr_r, sysr_r, cysr_r;
  logic signed [31:0] spb_r, srb_r, crb_r;
  // stage C: three-factor products, two-factor terms carried
  logic vc_r;
  logic signed [63:0] cyspsr_r, cyspcr_r, syspsr_r, syspcr_r;
  logic signed [63:0] cycp_c_r, sycp_c_r, cpsr_c_r, cpcr_c_r;
  logic signed [63:0] sycr_c_r, cycr_c_r, sysr_c_r, cysr_c_r;
  logic signed [31:0] spc_r;
  // output register
  logic vo_r;
  logic [e2irm_pkg::OUT_BITS-1:0] m_r [9];

  logic signed [31:0] cysp_q, sysp_q;
  logic signed [65:0] sum [9];
  logic [e2irm_pkg::OUT_BITS-1:0] m_nxt [9];

  function automatic logic signed [31:0] fix(input logic signed [31:0] v, input logic f);
    return f ? -v : v;
  endfunction

  // round Q60 to Q30, half up
  function automatic logic signed [31:0] q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  // round Q60 to output format and clamp to +-1.0
  function automatic logic [e2irm_pkg::OUT_BITS-1:0] finish(input logic signed [65:0] q);
    logic signed [65:0] v;
    logic signed [65:0] one;
    one = 66'sd1 <<< e2irm_pkg::COEF_FRAC_BITS;
    v   = (q + (66'sd1 <<< (SH - 1))) >>> SH;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[e2irm_pkg::OUT_BITS-1:0];
  endfunction

  assign cysp_q = q30(cysp_r);
  assign sysp_q = q30(sysp_r);

  // element sums
  always_comb begin
    sum[0] = 66'(cycp_c_r);
    sum[1] = 66'(sycp_c_r);
    sum[2] = -(66'(spc_r) <<< 30);
    sum[3] = 66'(cyspsr_r) - 66'(sycr_c_r);
    sum[4] = 66'(syspsr_r) + 66'(cycr_c_r);
    sum[5] = 66'(cpsr_c_r);
    sum[6] = 66'(cyspcr_r) + 66'(sysr_c_r);
    sum[7] = 66'(syspcr_r) - 66'(cysr_c_r);
    sum[8] = 66'(cpcr_c_r);
    for (int k = 0; k < 9; k++) begin
      m_nxt[k] = finish(sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= prev_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vo_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= fix(prev_lane[0].y, prev_lane[0].flip);
      cr_r <= fix(prev_lane[0].x, prev_lane[0].flip);
      sp_r <= fix(prev_lane[1].y, prev_lane[1].flip);
      cp_r <= fix(prev_lane[1].x, prev_lane[1].flip);
      sy_r <= fix(prev_lane[2].y, prev_lane[2].flip);
      cy_r <= fix(prev_lane[2].x, prev_lane[2].flip);

      cycp_r <= cy_r * cp_r;
      sycp_r <= sy_r * cp_r;
      cysp_r <= cy_r * sp_r;
      sysp_r <= sy_r * sp_r;
      cpsr_r <= cp_r * sr_r;
      cpcr_r <= cp_r * cr_r;
      sycr_r <= sy_r * cr_r;
      cycr_r <= cy_r * cr_r;
      sysr_r <= sy_r * sr_r;
      cysr_r <= cy_r * sr_r;
      spb_r  <= sp_r;
      srb_r  <= sr_r;
      crb_r  <= cr_r;

      cyspsr_r <= cysp_q * srb_r;
      cyspcr_r <= cysp_q * crb_r;
      syspsr_r <= sysp_q * srb_r;
      syspcr_r <= sysp_q * crb_r;
      cycp_c_r <= cycp_r;
      sycp_c_r <= sycp_r;
      cpsr_c_r <= cpsr_r;
      cpcr_c_r <= cpcr_r;
      sycr_c_r <= sycr_r;
      cycr_c_r <= cycr_r;
      sysr_c_r <= sysr_r;
      cysr_c_r <= cysr_r;
      spc_r    <= spb_r;

      m_r <= m_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_m     = m_r;

endmodule

// ===== sv/e2irm_checker.sv =====
// Port-level checks of the rotation matrix unit, bound to the top level.
// Depends on e2irm_pkg and the assertion macro header.
`include "euler_to_inverse_rotation_matrix_unit_macros.svh"

module e2irm_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_00,
  input logic signed [e2irm_pkg::OUT_BITS-1:0]  out_m_22
);

  localparam logic signed [e2irm_pkg::OUT_BITS-1:0] ONE =
    e2irm_pkg::OUT_BITS'(1 << e2irm_pkg::COEF_FRAC_BITS);

  // a held result stays
  `E2IRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `E2IRM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_m_22))
  // intake only backs up behind a held result
  `E2IRM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // elements 00 and 22 stay within +-1.0
  `E2IRM_ASSERT_NOW(a_range, out_valid,
    out_m_00 <= ONE && out_m_00 >= -ONE && out_m_22 <= ONE && out_m_22 >= -ONE)

endmodule

bind euler_to_inverse_rotation_matrix_unit e2irm_checker u_e2irm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_m_00  (out_m_00),
  .out_m_22  (out_m_22)
);

// ===== bench/euler_to_inverse_rotation_matrix_unit_test.sv =====
// Testbench for the rotation matrix unit: directed and random angle triples.
// Depends on e2irm_pkg and euler_to_inverse_rotation_matrix_unit.
module euler_to_inverse_rotation_matrix_unit_test;

  typedef logic signed [e2irm_pkg::OUT_BITS-1:0] elem_t;
  typedef struct {
    elem_t m [9];
  } matrix_t;

  localparam int LATENCY = 33;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_roll_angle = '0;
  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_pitch_angle = '0;
  logic signed [e2irm_pkg::ANGLE_BITS-1:0] in_yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  elem_t out_m_00, out_m_01, out_m_02, out_m_10, out_m_11, out_m_12;
  elem_t out_m_20, out_m_21, out_m_22;

  matrix_t expected_matrices[$];
  int error_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  euler_to_inverse_rotation_matrix_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle(in_yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m_00(out_m_00), .out_m_01(out_m_01), .out_m_02(out_m_02),
    .out_m_10(out_m_10), .out_m_11(out_m_11), .out_m_12(out_m_12),
    .out_m_20(out_m_20), .out_m_21(out_m_21), .out_m_22(out_m_22)
  );

  always #10 clk = ~clk;

  // Floor division by a power of two on signed values.
  function automatic longint floor_shr(input longint v, input int s);
    return v < 0 ? -64'sd1 - ((-64'sd1 - v) >>> s) : v >>> s;
  endfunction

  // Rotation-mode CORDIC sine and cosine in Q30, with half-turn fold.
  function automatic void cordic_sincos(input logic [e2irm_pkg::ANGLE_BITS-1:0] ang,
                                        output longint s, output longint c);
    logic [31:0] phase;
    logic fold;
    longint x, y, z, dx, dy;
    phase = {ang, {(32 - e2irm_pkg::ANGLE_BITS){1'b0}}};
    fold = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (fold) phase = phase + 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(phase));
    for (int i = 0; i < e2irm_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2irm_pkg::ATAN_TURN32[i]);
      end else begin
        x += dx; y -= dy; z += longint'(e2irm_pkg::ATAN_TURN32[i]);
      end
    end
    if (fold) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint round_q30(input longint a, input longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // Q60 sum to Q2.14 with round half up and clamp to +-1.0.
  function automatic elem_t to_coef(input longint q60);
    longint v, one;
    int sh;
    sh = 60 - e2irm_pkg::COEF_FRAC_BITS;
    one = 64'sd1 <<< e2irm_pkg::COEF_FRAC_BITS;
    v = floor_shr(q60 + (64'sd1 <<< (sh - 1)), sh);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return elem_t'(v);
  endfunction

  function automatic matrix_t inverse_rotation(
      input logic [e2irm_pkg::ANGLE_BITS-1:0] roll,
      input logic [e2irm_pkg::ANGLE_BITS-1:0] pitch,
      input logic [e2irm_pkg::ANGLE_BITS-1:0] yaw);
    matrix_t r;
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    cordic_sincos(roll, sr, cr);
    cordic_sincos(pitch, sp, cp);
    cordic_sincos(yaw, sy, cy);
    cysp = round_q30(cy, sp);
    sysp = round_q30(sy, sp);
    r.m[0] = to_coef(cy * cp);
    r.m[1] = to_coef(sy * cp);
    r.m[2] = to_coef(-sp * (64'sd1 <<< 30));
    r.m[3] = to_coef(cysp * sr - sy * cr);
    r.m[4] = to_coef(sysp * sr + cy * cr);
    r.m[5] = to_coef(cp * sr);
    r.m[6] = to_coef(cysp * cr + sy * sr);
    r.m[7] = to_coef(sysp * cr - cy * sr);
    r.m[8] = to_coef(cp * cr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int idx,
                                 input int got, input int want);
    error_count++;
    $display("MISMATCH beat %0d %s[%0d]: got %0d, expected %0d",
             beats_checked, what, idx, got, want);
  endtask

  // Send one angle triple, with random idle cycles ahead of it.
  task automatic send_angles(input logic [e2irm_pkg::ANGLE_BITS-1:0] roll,
                             input logic [e2irm_pkg::ANGLE_BITS-1:0] pitch,
                             input logic [e2irm_pkg::ANGLE_BITS-1:0] yaw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_roll_angle <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle <= yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_matrices.push_back(inverse_rotation(roll, pitch, yaw));
    beats_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    go_idle();
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // Receiver stall and result check.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_matrices.size() == 0) begin
          report_mismatch("unexpected", 0, 0, 0);
        end else begin
          matrix_t want;
          elem_t got [9];
          want = expected_matrices.pop_front();
          got = '{out_m_00, out_m_01, out_m_02, out_m_10, out_m_11, out_m_12,
                  out_m_20, out_m_21, out_m_22};
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.m[k]) report_mismatch("m", k, got[k], want.m[k]);
          beats_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("euler_to_inverse_rotation_matrix_unit_test: done, errors");
      $finish;
    end
  end

  // Extremes, axis angles and quadrant borders on the roll and pitch axes.
  task automatic test_directed_angles();
    logic [e2irm_pkg::ANGLE_BITS-1:0] corners [10];
    corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000,
                16'hC000, 16'h3FFF, 16'hBFFF, 16'h2000, 16'h0001};
    send_angles('0, '0, '0);
    for (int k = 1; k < 10; k++) begin
      send_angles(corners[k], '0, '0);
      send_angles('0, corners[k], '0);
    end
    send_angles(16'h7FFF, 16'h8000, 16'hFFFF);
    send_angles(16'h8000, 16'h4000, 16'hC000);
    send_angles(16'hAAAA, 16'h5555, 16'h2000);
    drain_results();
  endtask

  task automatic test_random_angles(input int count);
    for (int k = 0; k < count; k++)
      send_angles(e2irm_pkg::ANGLE_BITS'($urandom_range(16'hFFFF)),
                  e2irm_pkg::ANGLE_BITS'($urandom_range(16'hFFFF)),
                  e2irm_pkg::ANGLE_BITS'($urandom_range(16'hFFFF)));
  endtask

  // Gimbal lock region, pitch near +-pi/2.
  task automatic test_pitch_near_vertical(input int count);
    for (int k = 0; k < count; k++)
      send_angles(e2irm_pkg::ANGLE_BITS'($urandom),
                  e2irm_pkg::ANGLE_BITS'((k[0] ? 16'h4000 : 16'hC000)
                                         + $urandom_range(8) - 4),
                  e2irm_pkg::ANGLE_BITS'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_stall_pct = 87;
    test_directed_angles();
    test_random_angles(300);
    drain_results();

    send_idle_pct = 87;
    recv_stall_pct = 15;
    test_pitch_near_vertical(50);
    test_random_angles(250);
    drain_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_angles(400);
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d angle triples, %0d matrices checked, axis corners and pitch lock",
             beats_sent, beats_checked);
    if (error_count == 0 && expected_matrices.size() == 0) begin
      $display("euler_to_inverse_rotation_matrix_unit_test: done, clean");
    end else begin
      $display("euler_to_inverse_rotation_matrix_unit_test: done, errors");
    end
    $finish;
  end
endmodule
